// ===== rtl/cfp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types, constants and the CRC-8 byte update for the chassis frame
// parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

  // Frame delimiters and limits.
  localparam logic [7:0] HDR0     = 8'h55;
  localparam logic [7:0] HDR1     = 8'hAA;
  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] MIN_LEN  = 8'd7;

  // Number of payload bytes that are captured.
  localparam int PAYLOAD_BYTES = 7;
  localparam int PIDX_W        = $clog2(PAYLOAD_BYTES + 1);

  // Angle division by a constant, done as a multiply by a rounded-up reciprocal.
  localparam int ANGLE_DIV    = 88;
  localparam int RECIP_SHIFT  = 22;
  localparam int RECIP_INT    = ((2 ** RECIP_SHIFT) + ANGLE_DIV - 1) / ANGLE_DIV;
  localparam logic [15:0] ANGLE_RECIP = 16'(RECIP_INT);

  // Field widths.
  localparam int SPEED_W = 16;
  localparam int ANGLE_W = 10;
  localparam int CTRL_W  = 8;
  localparam int PROD_W  = 32;

  // Output stream data width: fields packed, padded to whole bytes.
  localparam int FIELDS_W = 2 * SPEED_W + ANGLE_W + CTRL_W;
  localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
  localparam int PAD_W    = TDATA_W - FIELDS_W;

  // Depth of the queue between the parser and the result stage.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Parser phases.
  typedef enum logic [2:0] {
    PH_HUNT0,
    PH_HUNT1,
    PH_LEN,
    PH_PAYLOAD,
    PH_CRC
  } phase_e;

  // Frame status codes.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_CRC   = 2'd1,
    STAT_SHORT = 2'd2
  } status_e;

  // One finished frame as handed from the parser to the result stage.
  typedef struct packed {
    status_e            status;
    logic [CTRL_W-1:0]  ctrl;
    logic [15:0]        angle_raw;
    logic [SPEED_W-1:0] right;
    logic [SPEED_W-1:0] left;
  } frame_t;

  // Reflected CRC-8 update over one byte.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // CRC state after both header bytes.
  localparam logic [7:0] CRC_AFTER_HDR = crc8_byte(crc8_byte(8'h00, HDR0), HDR1);

endpackage

// ===== rtl/cfp_front.sv =====
// ----------------------------------------------------------------------------
// cfp_front
// Byte parser: header hunt, length, payload capture and CRC check. Pushes one
// frame record per finished frame into the queue.
// ----------------------------------------------------------------------------
module cfp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           byte_valid_i,
  output logic           byte_ready_o,
  input  logic [7:0]     byte_i,
  input  logic           queue_full_i,
  output logic           push_o,
  output cfp_pkg::frame_t push_data_o
);
  import cfp_pkg::*;

  phase_e            phase_q, phase_d;
  logic [7:0]        left_q, left_d;
  logic [7:0]        crc_q, crc_d;
  logic [PIDX_W-1:0] idx_q, idx_d;
  logic [7:0]        pay_q [PAYLOAD_BYTES];
  logic              accept;
  logic              idx_live;

  // A byte is taken whenever the queue can hold a possible frame record.
  assign byte_ready_o = ~queue_full_i;
  assign accept       = byte_valid_i & byte_ready_o;
  assign idx_live     = (idx_q < PIDX_W'(PAYLOAD_BYTES));

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      case (phase_q)
        PH_HUNT0: begin
          if (byte_i == HDR0) phase_d = PH_HUNT1;
        end
        PH_HUNT1: begin
          if (byte_i == HDR1) phase_d = PH_LEN;
          else if (byte_i != HDR0) phase_d = PH_HUNT0;
        end
        PH_LEN: begin
          phase_d = (byte_i < MIN_LEN) ? PH_HUNT0 : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (left_q == 8'd1) phase_d = PH_CRC;
        end
        PH_CRC: begin
          phase_d = PH_HUNT0;
        end
        default: begin
          phase_d = PH_HUNT0;
        end
      endcase
    end
  end

  // Counters and running CRC.
  always_comb begin
    left_d = left_q;
    crc_d  = crc_q;
    idx_d  = idx_q;
    if (accept) begin
      case (phase_q)
        PH_HUNT1: begin
          crc_d = CRC_AFTER_HDR;
        end
        PH_LEN: begin
          left_d = byte_i;
          crc_d  = crc8_byte(crc_q, byte_i);
          idx_d  = '0;
        end
        PH_PAYLOAD: begin
          left_d = left_q - 8'd1;
          crc_d  = crc8_byte(crc_q, byte_i);
          if (idx_live) idx_d = idx_q + PIDX_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Frame record output.
  always_comb begin
    push_o      = 1'b0;
    push_data_o = '0;
    if (accept) begin
      case (phase_q)
        PH_LEN: begin
          if (byte_i < MIN_LEN) begin
            push_o             = 1'b1;
            push_data_o.status = STAT_SHORT;
          end
        end
        PH_CRC: begin
          push_o = 1'b1;
          if (byte_i != crc_q) begin
            push_data_o.status = STAT_CRC;
          end else begin
            push_data_o.status    = STAT_OK;
            push_data_o.left      = {pay_q[1], pay_q[0]};
            push_data_o.right     = {pay_q[3], pay_q[2]};
            push_data_o.angle_raw = {pay_q[5], pay_q[4]};
            push_data_o.ctrl      = pay_q[6];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT0;
      left_q  <= '0;
      crc_q   <= '0;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      crc_q   <= crc_d;
      idx_q   <= idx_d;
    end
  end

  // Payload capture of the first bytes of the frame.
  always_ff @(posedge clk_i) begin
    if (accept && (phase_q == PH_PAYLOAD) && idx_live) begin
      pay_q[idx_q[PIDX_W-1:0]] <= byte_i;
    end
  end

endmodule

// ===== rtl/cfp_queue.sv =====
// ----------------------------------------------------------------------------
// cfp_queue
// Short first-in first-out queue of frame records between parser and result
// stage.
// ----------------------------------------------------------------------------
module cfp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cfp_pkg::frame_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output cfp_pkg::frame_t pop_data_o,
  output logic            empty_o
);
  import cfp_pkg::*;

  frame_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o     = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) count_d = count_q + (QPTR_W + 1)'(1);
    else if (do_pop && !do_push) count_d = count_q - (QPTR_W + 1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/cfp_back.sv =====
// ----------------------------------------------------------------------------
// cfp_back
// Result stage: scales the raw angle by 1/88 through a reciprocal multiply and
// drives the output stream from a registered stage.
// ----------------------------------------------------------------------------
module cfp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        queue_empty_i,
  input  cfp_pkg::frame_t             queue_data_i,
  output logic                        pop_o,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [cfp_pkg::TDATA_W-1:0] res_data_o,
  output logic [1:0]                  res_user_o
);
  import cfp_pkg::*;

  // Multiply stage.
  logic               a_valid_q;
  status_e            a_status_q;
  logic [SPEED_W-1:0] a_left_q;
  logic [SPEED_W-1:0] a_right_q;
  logic [CTRL_W-1:0]  a_ctrl_q;
  logic               a_neg_q;
  logic [PROD_W-1:0]  a_prod_q;
  // Output stage.
  logic               o_valid_q;
  status_e            o_status_q;
  logic [SPEED_W-1:0] o_left_q;
  logic [SPEED_W-1:0] o_right_q;
  logic [ANGLE_W-1:0] o_angle_q;
  logic [CTRL_W-1:0]  o_ctrl_q;

  logic               o_load;
  logic               a_load;
  logic               in_neg;
  logic [15:0]        in_mag;
  logic [ANGLE_W-1:0] quot;
  logic [ANGLE_W-1:0] angle_d;

  // Stages advance whenever the next one is free or draining.
  assign o_load = a_valid_q & (~o_valid_q | res_ready_i);
  assign a_load = ~a_valid_q | o_load;
  assign pop_o  = a_load & ~queue_empty_i;

  // Magnitude of the signed raw angle.
  assign in_neg = queue_data_i.angle_raw[15];
  assign in_mag = in_neg ? (16'd0 - queue_data_i.angle_raw) : queue_data_i.angle_raw;

  // Quotient of the magnitude, then sign restored (truncation toward zero).
  assign quot    = a_prod_q[RECIP_SHIFT +: ANGLE_W];
  assign angle_d = a_neg_q ? (ANGLE_W'(0) - quot) : quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (a_load) a_valid_q <= ~queue_empty_i;
      if (o_load) o_valid_q <= 1'b1;
      else if (res_ready_i) o_valid_q <= 1'b0;
    end
  end

  // Payload of the multiply stage.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_status_q <= queue_data_i.status;
      a_left_q   <= queue_data_i.left;
      a_right_q  <= queue_data_i.right;
      a_ctrl_q   <= queue_data_i.ctrl;
      a_neg_q    <= in_neg;
      a_prod_q   <= in_mag * ANGLE_RECIP;
    end
  end

  // Payload of the output stage.
  always_ff @(posedge clk_i) begin
    if (o_load) begin
      o_status_q <= a_status_q;
      o_left_q   <= a_left_q;
      o_right_q  <= a_right_q;
      o_angle_q  <= angle_d;
      o_ctrl_q   <= a_ctrl_q;
    end
  end

  assign res_valid_o = o_valid_q;
  assign res_data_o  = {{PAD_W{1'b0}}, o_ctrl_q, o_angle_q, o_right_q, o_left_q};
  assign res_user_o  = o_status_q;

endmodule

// ===== rtl/chassis_frame_parser_core.sv =====
// Path: the byte that ends a frame (CRC byte or short length byte) pushes its
// record into the queue; the record then passes the multiply and output stages.
// Throughput: one received byte per cycle; the parser stalls only when the
// two-entry frame queue is full. The result stage takes one frame per cycle while m_axis_tready is high.
// Reset: asynchronous and active low; the parser returns to header hunting and
// the queue and result stages are emptied.
// ----------------------------------------------------------------------------
// chassis_frame_parser_core
// Serial frame parser with CRC-8 check, payload field extraction and angle
// scaling, with a queue between the byte parser and the result stage.
// ----------------------------------------------------------------------------
module chassis_frame_parser_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Received byte stream.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] rx_byte
  // Frame result stream.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [15:0] left_speed, [31:16] right_speed, [41:32] angle_value,
  // [49:42] control_bits, upper bits zero.
  output logic [cfp_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [1:0]                  m_axis_tuser   // [1:0] frame_status
);
  import cfp_pkg::*;

  logic   push;
  frame_t push_data;
  logic   queue_full;
  logic   pop;
  frame_t pop_data;
  logic   queue_empty;

  // Byte parser.
  cfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // Frame record queue.
  cfp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (queue_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (queue_empty)
  );

  // Result stage.
  cfp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (queue_empty),
    .queue_data_i  (pop_data),
    .pop_o         (pop),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_data_o    (m_axis_tdata),
    .res_user_o    (m_axis_tuser)
  );

endmodule

// ===== sim/frame_checker.sv =====
// ----------------------------------------------------------------------------
// frame_checker
// Watches the byte and result streams of the chassis frame parser. It runs
// its own parser over every accepted byte and compares each accepted result
// with the oldest frame it predicted.
// ----------------------------------------------------------------------------
package frame_tb_pkg;

  // Reflected CRC-8, one byte folded in bit by bit, lowest bit first.
  function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    repeat (8) begin
      c = {1'b0, c[7:1]} ^ (c[0] ? cfp_pkg::CRC_POLY : 8'h00);
    end
    return c;
  endfunction

endpackage

module frame_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Byte stream as seen at the parser input.
  input  logic                        rx_valid_i,
  input  logic                        rx_ready_i,
  input  logic [7:0]                  rx_data_i,    // [7:0] rx_byte
  // Result stream as seen at the parser output.
  input  logic                        res_valid_i,
  input  logic                        res_ready_i,
  // [15:0] left_speed, [31:16] right_speed, [41:32] angle_value,
  // [49:42] control_bits, upper bits zero.
  input  logic [cfp_pkg::TDATA_W-1:0] res_data_i,
  input  logic [1:0]                  res_user_i,   // [1:0] frame_status
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          ok_seen_o,
  output int                          crc_seen_o,
  output int                          short_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import cfp_pkg::*;
  import frame_tb_pkg::crc8_fold;

  typedef struct {
    status_e            status;
    logic [TDATA_W-1:0] data;
  } frame_result_t;

  // Frames predicted but not yet seen on the output.
  frame_result_t expected_frames[$];

  // Shadow parser state.
  phase_e     hunt_phase;
  logic [7:0] frame_len;
  logic [7:0] bytes_left;
  logic [7:0] crc_acc;
  logic [7:0] payload [PAYLOAD_BYTES];

  int fails      = 0;
  int pending    = 0;
  int ok_seen    = 0;
  int crc_seen   = 0;
  int short_seen = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;
  assign ok_seen_o    = ok_seen;
  assign crc_seen_o   = crc_seen;
  assign short_seen_o = short_seen;

  task automatic push_frame(input status_e status, input logic [15:0] left,
                            input logic [15:0] right, input logic [9:0] angle,
                            input logic [7:0] ctrl);
    frame_result_t r;
    r.status = status;
    r.data   = {{PAD_W{1'b0}}, ctrl, angle, right, left};
    expected_frames.push_back(r);
  endtask

  // Advance the shadow parser by one byte, queueing a frame when one ends.
  task automatic take_rx_byte(input logic [7:0] b);
    logic [7:0] idx;
    int         angle_q;
    case (hunt_phase)
      PH_HUNT0: begin
        if (b == HDR0) hunt_phase = PH_HUNT1;
      end
      PH_HUNT1: begin
        // A repeated first header byte keeps us waiting for the second one.
        if (b == HDR1) begin
          crc_acc    = crc8_fold(crc8_fold(8'h00, HDR0), HDR1);
          hunt_phase = PH_LEN;
        end else if (b != HDR0) begin
          hunt_phase = PH_HUNT0;
        end
      end
      PH_LEN: begin
        if (b < MIN_LEN) begin
          push_frame(STAT_SHORT, '0, '0, '0, '0);
          hunt_phase = PH_HUNT0;
        end else begin
          frame_len  = b;
          bytes_left = b;
          crc_acc    = crc8_fold(crc_acc, b);
          hunt_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        // Bytes past the seventh only feed the CRC.
        idx = frame_len - bytes_left;
        if (idx < PAYLOAD_BYTES) payload[idx] = b;
        crc_acc    = crc8_fold(crc_acc, b);
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) hunt_phase = PH_CRC;
      end
      PH_CRC: begin
        hunt_phase = PH_HUNT0;
        if (b != crc_acc) begin
          push_frame(STAT_CRC, '0, '0, '0, '0);
        end else begin
          // Signed division truncates toward zero.
          angle_q = $signed({payload[5], payload[4]}) / ANGLE_DIV;
          push_frame(STAT_OK, {payload[1], payload[0]}, {payload[3], payload[2]},
                     angle_q[9:0], payload[6]);
        end
      end
      default: hunt_phase = PH_HUNT0;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
      fails++;
    end
  endtask

  // Compare one accepted result with the oldest predicted frame.
  task automatic compare_result();
    frame_result_t e;
    case (res_user_i)
      STAT_OK:    ok_seen++;
      STAT_CRC:   crc_seen++;
      STAT_SHORT: short_seen++;
      default:    ;
    endcase
    if (expected_frames.size() == 0) begin
      $display("%0t: unexpected result, expected none, got status %h data %h",
               $realtime, res_user_i, res_data_i);
      fails++;
    end else begin
      e = expected_frames.pop_front();
      check_field("frame_status", 32'(e.status),       32'(res_user_i));
      check_field("left_speed",   32'(e.data[15:0]),   32'(res_data_i[15:0]));
      check_field("right_speed",  32'(e.data[31:16]),  32'(res_data_i[31:16]));
      check_field("angle_value",  32'(e.data[41:32]),  32'(res_data_i[41:32]));
      check_field("control_bits", 32'(e.data[49:42]),  32'(res_data_i[49:42]));
      check_field("padding",      32'(e.data[TDATA_W-1:FIELDS_W]),
                                  32'(res_data_i[TDATA_W-1:FIELDS_W]));
    end
  endtask

  // Both streams are sampled on the rising edge; results first, then bytes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunt_phase = PH_HUNT0;
      frame_len  = 8'd0;
      bytes_left = 8'd0;
      crc_acc    = 8'd0;
      expected_frames.delete();
    end else begin
      if (res_valid_i && res_ready_i) compare_result();
      if (rx_valid_i && rx_ready_i) take_rx_byte(rx_data_i);
    end
    pending = expected_frames.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives received bytes into the chassis frame parser: directed frames for
// the field extremes and the header, length and checksum corner cases, then
// random frames mixed with noise, with random idling on both streams and one
// long output hold-off. The checker beside the parser does the comparing.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cfp_pkg::*;
  import frame_tb_pkg::crc8_fold;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 5;
  localparam int RANDOM_BYTES   = 190;
  localparam int CALM_AFTER     = 130;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               rx_tvalid;
  logic               rx_tready;
  logic [7:0]         rx_tdata;
  logic               res_tvalid;
  logic               res_tready;
  logic [TDATA_W-1:0] res_tdata;
  logic [1:0]         res_tuser;

  int fails;
  int pending;
  int ok_seen;
  int crc_seen;
  int short_seen;

  int rx_bytes  = 0;
  bit calm      = 1'b0;
  bit hold_req  = 1'b0;
  bit hold_used = 1'b0;
  int idle_cycles;

  always #(CLK_PERIOD / 2) clk = ~clk;

  chassis_frame_parser_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (rx_tvalid),
    .s_axis_tready (rx_tready),
    .s_axis_tdata  (rx_tdata),
    .m_axis_tvalid (res_tvalid),
    .m_axis_tready (res_tready),
    .m_axis_tdata  (res_tdata),
    .m_axis_tuser  (res_tuser)
  );

  frame_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .rx_valid_i   (rx_tvalid),
    .rx_ready_i   (rx_tready),
    .rx_data_i    (rx_tdata),
    .res_valid_i  (res_tvalid),
    .res_ready_i  (res_tready),
    .res_data_i   (res_tdata),
    .res_user_i   (res_tuser),
    .fail_count_o (fails),
    .pending_o    (pending),
    .ok_seen_o    (ok_seen),
    .crc_seen_o   (crc_seen),
    .short_seen_o (short_seen)
  );

  // Offer one byte, with an optional idle burst first, and hold the request
  // until the parser accepts it.
  task automatic put_byte(input logic [7:0] b);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      rx_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    rx_tvalid <= 1'b1;
    rx_tdata  <= b;
    do @(posedge clk); while (!rx_tready);
    rx_bytes++;
  endtask

  // The seven captured payload bytes, lowest first.
  function automatic logic [55:0] make_fields(input logic [15:0] left,
                                              input logic [15:0] right,
                                              input logic [15:0] angle_raw,
                                              input logic [7:0] ctrl);
    return {ctrl, angle_raw, right, left};
  endfunction

  // Speeds and angles lean on the sign and range boundaries now and then.
  function automatic logic [15:0] pick_word();
    logic [15:0] edges [4];
    edges = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
    if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 3)];
    return 16'($urandom);
  endfunction

  // Header, length, payload and CRC byte; the CRC is spoiled on request.
  task automatic send_frame(input logic [7:0] len, input logic [55:0] fields,
                            input bit bad_crc);
    logic [7:0] crc;
    logic [7:0] b;
    crc = crc8_fold(crc8_fold(8'h00, HDR0), HDR1);
    put_byte(HDR0);
    put_byte(HDR1);
    put_byte(len);
    crc = crc8_fold(crc, len);
    for (int i = 0; i < int'(len); i++) begin
      b = (i < PAYLOAD_BYTES) ? fields[8*i +: 8] : 8'($urandom);
      put_byte(b);
      crc = crc8_fold(crc, b);
    end
    if (bad_crc) crc = crc ^ 8'($urandom_range(1, 255));
    put_byte(crc);
  endtask

  task automatic send_short(input logic [7:0] len);
    put_byte(HDR0);
    put_byte(HDR1);
    put_byte(len);
  endtask

  function automatic logic [55:0] random_fields();
    return make_fields(pick_word(), pick_word(), pick_word(), 8'($urandom));
  endfunction

  // Receiver: random ready bursts, one long hold-off, no idling when calm.
  initial begin
    res_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        res_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        res_tready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        res_tready <= 1'b1;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk);
      end
    end
  end

  // Watchdog on cycles without any accepted request.
  initial begin
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((rx_tvalid && rx_tready) || (res_tvalid && res_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: watchdog expired, %0d results still outstanding", $realtime, pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int start_bytes;
    int pick;
    int len;
    rst_n     = 1'b0;
    rx_tvalid = 1'b0;
    rx_tdata  = 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Field extremes, including the largest and smallest angle quotients.
    send_frame(8'd7, make_fields(16'h0000, 16'h0000, 16'h0000, 8'h00), 1'b0);
    send_frame(8'd7, make_fields(16'h7FFF, 16'h8000, 16'h7FFF, 8'hFF), 1'b0);
    send_frame(8'd7, make_fields(16'h8000, 16'h7FFF, 16'h8000, 8'h00), 1'b0);
    send_frame(8'd7, make_fields(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hA5), 1'b0);
    // Angles around one step of the divider, both signs.
    send_frame(8'd8, make_fields(16'h0001, 16'h0100, 16'hFFA8, 8'h5A), 1'b0);
    send_frame(8'd7, make_fields(16'h1234, 16'hEDCB, 16'hFFA9, 8'h01), 1'b0);
    send_frame(8'd7, make_fields(16'h00FF, 16'hFF00, 16'h0057, 8'h80), 1'b0);
    send_frame(8'd7, make_fields(16'h5555, 16'hAAAA, 16'h0058, 8'h7F), 1'b0);
    // Lengths below seven end the frame at once.
    send_short(8'd0);
    send_short(8'd6);
    // Checksum mismatch.
    send_frame(8'd7, random_fields(), 1'b1);
    // Repeated first header byte before the second one.
    put_byte(HDR0);
    put_byte(HDR0);
    send_frame(8'd7, random_fields(), 1'b0);
    // Broken header, then a stray second header byte, then trailer bytes.
    put_byte(HDR0);
    put_byte(8'h00);
    put_byte(HDR1);
    // Long payloads, the longest length among them.
    send_frame(8'd40, random_fields(), 1'b0);
    put_byte(8'hAA);
    put_byte(8'hFF);
    send_frame(8'd255, random_fields(), 1'b0);

    // Hold the output off while short frames keep coming, so the queue fills.
    hold_req = 1'b1;
    repeat (12) send_short(8'($urandom_range(0, 6)));

    // Random traffic: mostly well-formed frames, plus noise and broken ones.
    start_bytes = rx_bytes;
    while (rx_bytes - start_bytes < RANDOM_BYTES) begin
      if (rx_bytes - start_bytes >= CALM_AFTER) calm = 1'b1;
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(7, 12);
      if (pick < 62) begin
        send_frame(8'(len), random_fields(), 1'b0);
      end else if (pick < 72) begin
        send_frame(8'(len), random_fields(), 1'b1);
      end else if (pick < 80) begin
        send_short(8'($urandom_range(0, 6)));
      end else if (pick < 88) begin
        // Repeated or broken header ahead of a real frame.
        repeat ($urandom_range(1, 3)) put_byte(HDR0);
        if ($urandom_range(0, 1) == 0) put_byte(8'($urandom_range(0, 84)));
        send_frame(8'(len), random_fields(), 1'b0);
      end else begin
        // Line noise; a first header byte is kept out so no frame is swallowed.
        repeat ($urandom_range(1, 5)) begin
          put_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 84))
                                               : 8'($urandom_range(86, 255)));
        end
      end
    end

    @(negedge clk);
    rx_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes; checked %0d valid frames, %0d checksum errors, %0d short lengths,",
             rx_bytes, ok_seen, crc_seen, short_seen);
    $display("with random idling on both streams and one %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (fails == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== chassis_frame_parser_core.f =====
rtl/cfp_pkg.sv
rtl/cfp_front.sv
rtl/cfp_queue.sv
rtl/cfp_back.sv
rtl/chassis_frame_parser_core.sv
sim/frame_checker.sv
sim/tb_top.sv
